// ----- design/tcb_pkg.sv -----
// shared constants, codes and control types for the text console buffer
package tcb_pkg;

	localparam int MAX_COLUMNS = 128;
	localparam int MAX_ROWS    = 64;
	localparam int MEM_DEPTH   = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(MEM_DEPTH);

	localparam int ROW_W      = 6;
	localparam int COL_W      = 7;
	localparam int CHAR_W     = 8;
	localparam int CFG_COLS_W = 8;
	localparam int CFG_ROWS_W = 7;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd80;
	localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 7'd25;

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLUMNS = 1'b0,
		CFG_ROWS    = 1'b1
	} cfg_idx_t;

	typedef enum logic {
		OP_PUT  = 1'b0,
		OP_READ = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic in_ready;
		logic take;
		logic clr_step;
		logic exec;
		logic scroll_step;
		logic read_capture;
		logic out_load;
		logic out_direct;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic scroll_last;
		logic is_read;
		logic will_scroll;
		logic out_free;
	} status_t;

endpackage

// ----- design/tcb_if.sv -----
// valid/ready channels for request and response beats
interface tcb_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [tcb_pkg::CHAR_W-1:0]  char_code;
	logic [tcb_pkg::ROW_W-1:0]   read_row;
	logic [tcb_pkg::COL_W-1:0]   read_col;

	modport source (output valid, opcode, char_code, read_row, read_col, input ready);
	modport sink (input valid, opcode, char_code, read_row, read_col, output ready);
endinterface

interface tcb_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tcb_pkg::ROW_W-1:0]   cursor_row_out;
	logic [tcb_pkg::COL_W-1:0]   cursor_col_out;
	logic [tcb_pkg::CHAR_W-1:0]  cell_value;
	logic                        scrolled;

	modport source (output valid, cursor_row_out, cursor_col_out, cell_value, scrolled,
		input ready);
	modport sink (input valid, cursor_row_out, cursor_col_out, cell_value, scrolled,
		output ready);
endinterface

// ----- design/tcb_ctrl.sv -----
// sequencing state machine for the text console buffer
module tcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  tcb_pkg::status_t  status,
	output tcb_pkg::cmd_t     cmd
);

	tcb_pkg::state_t state_q;
	tcb_pkg::state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			tcb_pkg::ST_CLEAR: begin
				if (status.clr_last) state_next = tcb_pkg::ST_IDLE;
			end
			tcb_pkg::ST_IDLE: begin
				if (in_valid) state_next = tcb_pkg::ST_EXEC;
			end
			tcb_pkg::ST_EXEC: begin
				if (status.is_read) state_next = tcb_pkg::ST_READ;
				else if (status.will_scroll) state_next = tcb_pkg::ST_SCROLL;
				else if (status.out_free) state_next = tcb_pkg::ST_IDLE;
				else state_next = tcb_pkg::ST_DONE;
			end
			tcb_pkg::ST_READ: begin
				state_next = tcb_pkg::ST_DONE;
			end
			tcb_pkg::ST_SCROLL: begin
				if (status.scroll_last) state_next = tcb_pkg::ST_DONE;
			end
			tcb_pkg::ST_DONE: begin
				if (status.out_free) state_next = tcb_pkg::ST_IDLE;
			end
			default: begin
				state_next = tcb_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			tcb_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
			end
			tcb_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.take     = in_valid;
			end
			tcb_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				// plain put goes straight to the output slot when it is free
				if (!status.is_read && !status.will_scroll && status.out_free) begin
					cmd.out_load   = 1'b1;
					cmd.out_direct = 1'b1;
				end
			end
			tcb_pkg::ST_READ: begin
				cmd.read_capture = 1'b1;
			end
			tcb_pkg::ST_SCROLL: begin
				cmd.scroll_step = 1'b1;
			end
			tcb_pkg::ST_DONE: begin
				cmd.out_load = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// ----- design/tcb_datapath.sv -----
// cell store, cursor, scroll copy pipeline and output register
module tcb_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_write,
	input  logic [tcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcb_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic                             opcode,
	input  logic [tcb_pkg::CHAR_W-1:0]       char_code,
	input  logic [tcb_pkg::ROW_W-1:0]        read_row,
	input  logic [tcb_pkg::COL_W-1:0]        read_col,
	input  tcb_pkg::cmd_t                    cmd,
	output tcb_pkg::status_t                 status,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tcb_pkg::ROW_W-1:0]        cursor_row_out,
	output logic [tcb_pkg::COL_W-1:0]        cursor_col_out,
	output logic [tcb_pkg::CHAR_W-1:0]       cell_value,
	output logic                             scrolled
);

	localparam int PROD_W = tcb_pkg::ROW_W + tcb_pkg::CFG_COLS_W;
	localparam int KEEP_W = tcb_pkg::CFG_ROWS_W + tcb_pkg::CFG_COLS_W;

	logic [tcb_pkg::CFG_COLS_W-1:0] cols_q;
	logic [tcb_pkg::CFG_ROWS_W-1:0] rows_q;
	logic [tcb_pkg::ROW_W-1:0]      cur_row_q;
	logic [tcb_pkg::COL_W-1:0]      cur_col_q;
	tcb_pkg::op_t                   op_q;
	logic [tcb_pkg::CHAR_W-1:0]     char_q;
	logic [tcb_pkg::ROW_W-1:0]      rrow_q;
	logic [tcb_pkg::COL_W-1:0]      rcol_q;
	logic [tcb_pkg::ADDR_W-1:0]     idx_q;
	logic [tcb_pkg::ADDR_W-1:0]     keep_q;
	logic [tcb_pkg::ADDR_W-1:0]     last_q;
	logic                           scr_wr_s1;
	logic [tcb_pkg::ADDR_W-1:0]     scr_addr_s1;
	logic                           scr_zero_s1;
	logic                           in_range_q;
	logic [tcb_pkg::CHAR_W-1:0]     res_cell_q;
	logic                           res_scrolled_q;
	logic [tcb_pkg::CHAR_W-1:0]     rdata_q;
	logic                           out_valid_q;
	logic [tcb_pkg::ROW_W-1:0]      out_row_q;
	logic [tcb_pkg::COL_W-1:0]      out_col_q;
	logic [tcb_pkg::CHAR_W-1:0]     out_cell_q;
	logic                           out_scrolled_q;

	logic [tcb_pkg::CHAR_W-1:0]     mem [tcb_pkg::MEM_DEPTH];

	logic [tcb_pkg::CFG_COLS_W-1:0] eff_c;
	logic [tcb_pkg::CFG_ROWS_W-1:0] eff_r;
	logic [tcb_pkg::ROW_W-1:0]      r0;
	logic [tcb_pkg::COL_W-1:0]      c0;
	logic [tcb_pkg::COL_W-1:0]      c_back;
	logic [tcb_pkg::CFG_COLS_W-1:0] col_inc;
	logic [tcb_pkg::CFG_ROWS_W-1:0] row_inc;
	logic                           is_nl;
	logic                           is_bs;
	logic                           adv_row;
	logic                           will_scroll;
	logic                           put_wr;
	logic [tcb_pkg::ROW_W-1:0]      next_row;
	logic [tcb_pkg::COL_W-1:0]      next_col;
	logic [tcb_pkg::ROW_W-1:0]      mul_row;
	logic [tcb_pkg::COL_W-1:0]      mul_col;
	logic [PROD_W-1:0]              lin_sum;
	logic [tcb_pkg::ADDR_W-1:0]     lin_addr;
	logic [KEEP_W-1:0]              keep_prod;
	logic [KEEP_W-1:0]              last_sum;
	logic                           mem_we;
	logic [tcb_pkg::ADDR_W-1:0]     mem_waddr;
	logic [tcb_pkg::CHAR_W-1:0]     mem_wdata;
	logic [tcb_pkg::ADDR_W-1:0]     mem_raddr;
	logic                           out_free;

	// config registers, zero counts as one and large values saturate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= tcb_pkg::COLS_RESET;
			rows_q <= tcb_pkg::ROWS_RESET;
		end else if (cfg_write) begin
			case (tcb_pkg::cfg_idx_t'(cfg_index))
				tcb_pkg::CFG_COLUMNS: cols_q <= cfg_wdata;
				tcb_pkg::CFG_ROWS:    rows_q <= cfg_wdata[tcb_pkg::CFG_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (cols_q == '0) eff_c = tcb_pkg::CFG_COLS_W'(1);
		else if (cols_q > tcb_pkg::CFG_COLS_W'(tcb_pkg::MAX_COLUMNS))
			eff_c = tcb_pkg::CFG_COLS_W'(tcb_pkg::MAX_COLUMNS);
		else eff_c = cols_q;
		if (rows_q == '0) eff_r = tcb_pkg::CFG_ROWS_W'(1);
		else if (rows_q > tcb_pkg::CFG_ROWS_W'(tcb_pkg::MAX_ROWS))
			eff_r = tcb_pkg::CFG_ROWS_W'(tcb_pkg::MAX_ROWS);
		else eff_r = rows_q;
	end

	// put: clamp cursor, then work out where it goes
	always_comb begin
		r0 = ({1'b0, cur_row_q} >= eff_r) ? tcb_pkg::ROW_W'(eff_r - 1'b1) : cur_row_q;
		c0 = ({1'b0, cur_col_q} >= eff_c) ? tcb_pkg::COL_W'(eff_c - 1'b1) : cur_col_q;
		c_back  = (c0 != '0) ? c0 - 1'b1 : c0;
		col_inc = {1'b0, c0} + 1'b1;
		row_inc = {1'b0, r0} + 1'b1;
		is_nl   = (char_q == tcb_pkg::CH_NEWLINE);
		is_bs   = (char_q == tcb_pkg::CH_BACKSPACE);
		adv_row = is_nl || (!is_bs && (col_inc >= eff_c));
		will_scroll = (op_q == tcb_pkg::OP_PUT) && adv_row && (row_inc >= eff_r);
		put_wr  = (op_q == tcb_pkg::OP_PUT) && !is_nl;
		// on a scroll the row stays at the last line
		if (!adv_row || will_scroll) next_row = r0;
		else next_row = tcb_pkg::ROW_W'(row_inc);
		if (adv_row) next_col = '0;
		else if (is_bs) next_col = c_back;
		else next_col = tcb_pkg::COL_W'(col_inc);
	end

	// one multiplier forms the linear cell address for both puts and reads
	always_comb begin
		if (op_q == tcb_pkg::OP_READ) begin
			mul_row = rrow_q;
			mul_col = rcol_q;
		end else begin
			mul_row = r0;
			mul_col = is_bs ? c_back : c0;
		end
		lin_sum  = PROD_W'(mul_row) * PROD_W'(eff_c) + PROD_W'(mul_col);
		lin_addr = lin_sum[tcb_pkg::ADDR_W-1:0];
		keep_prod = KEEP_W'(eff_r - 1'b1) * KEEP_W'(eff_c);
		last_sum  = keep_prod + KEEP_W'(eff_c) - KEEP_W'(1);
	end

	// single write port: clear sweep, put, then scroll copy
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = lin_addr;
		mem_wdata = is_bs ? tcb_pkg::CH_SPACE : char_q;
		if (cmd.clr_step) begin
			mem_we    = 1'b1;
			mem_waddr = idx_q;
			mem_wdata = '0;
		end else if (cmd.exec && put_wr) begin
			mem_we = 1'b1;
		end else if (scr_wr_s1) begin
			mem_we    = 1'b1;
			mem_waddr = scr_addr_s1;
			mem_wdata = scr_zero_s1 ? '0 : rdata_q;
		end
		mem_raddr = cmd.scroll_step ? idx_q + tcb_pkg::ADDR_W'(eff_c) : lin_addr;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			scr_wr_s1 <= 1'b0;
		end else begin
			if (cmd.clr_step || cmd.scroll_step) idx_q <= idx_q + 1'b1;
			else if (cmd.exec) idx_q <= '0;
			scr_wr_s1 <= cmd.scroll_step;
		end
	end

	always_ff @(posedge clk) begin
		scr_addr_s1 <= idx_q;
		scr_zero_s1 <= (idx_q >= keep_q);
		if (cmd.take) begin
			op_q   <= tcb_pkg::op_t'(opcode);
			char_q <= char_code;
			rrow_q <= read_row;
			rcol_q <= read_col;
		end
		if (cmd.exec) begin
			keep_q         <= keep_prod[tcb_pkg::ADDR_W-1:0];
			last_q         <= last_sum[tcb_pkg::ADDR_W-1:0];
			in_range_q     <= ({1'b0, rrow_q} < eff_r) && ({1'b0, rcol_q} < eff_c);
			res_scrolled_q <= will_scroll;
			res_cell_q     <= '0;
		end else if (cmd.read_capture) begin
			res_cell_q <= in_range_q ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else if (cmd.exec && (op_q == tcb_pkg::OP_PUT)) begin
			cur_row_q <= next_row;
			cur_col_q <= next_col;
		end
	end

	// output register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_direct) begin
				out_row_q      <= next_row;
				out_col_q      <= next_col;
				out_cell_q     <= '0;
				out_scrolled_q <= 1'b0;
			end else begin
				out_row_q      <= cur_row_q;
				out_col_q      <= cur_col_q;
				out_cell_q     <= res_cell_q;
				out_scrolled_q <= res_scrolled_q;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign cursor_row_out = out_row_q;
	assign cursor_col_out = out_col_q;
	assign cell_value     = out_cell_q;
	assign scrolled       = out_scrolled_q;

	assign status.clr_last    = (idx_q == tcb_pkg::ADDR_W'(tcb_pkg::MEM_DEPTH - 1));
	assign status.scroll_last = (idx_q == last_q);
	assign status.is_read     = (op_q == tcb_pkg::OP_READ);
	assign status.will_scroll = will_scroll;
	assign status.out_free    = out_free;

endmodule

// ----- design/text_console_buffer_unit.sv -----
// top level of the text console buffer: controller plus datapath
//
// channel   dir   beat contents                                   handshake
// cmd_ch    in    opcode, char_code, read_row, read_col            valid/ready
// rsp_ch    out   cursor_row_out, cursor_col_out, cell_value,      valid/ready
//                 scrolled
// cfg       in    cfg_index, cfg_wdata                            cfg_write strobe
//
// a put beat: accept, then clamp/address/write in the EXEC state
// a read beat steps through accept, address and memory read, capture, response load
// a put that scrolls adds a copy pass over rows_in_use * columns_in_use cells: the copy runs one cell
// per cycle through the single memory write port
// after reset a clearing pass over all 8192 cells zeroes the cell memory; cmd_ch.ready stays low
// a stalled response waits in the output register; the next request beat is still accepted
module text_console_buffer_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	tcb_req_if.sink                          cmd_ch,
	tcb_rsp_if.source                        rsp_ch,
	input  logic                             cfg_write,
	input  logic [tcb_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tcb_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	tcb_pkg::cmd_t    ctl_cmd;
	tcb_pkg::status_t dp_status;

	// sequencer: clear sweep, item execution, scroll copy, result hand-off
	tcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (cmd_ch.valid),
		.status   (dp_status),
		.cmd      (ctl_cmd)
	);

	// request side only ready between items
	assign cmd_ch.ready = ctl_cmd.in_ready;

	// cell memory, cursor, config registers and response register
	tcb_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.opcode         (cmd_ch.opcode),
		.char_code      (cmd_ch.char_code),
		.read_row       (cmd_ch.read_row),
		.read_col       (cmd_ch.read_col),
		.cmd            (ctl_cmd),
		.status         (dp_status),
		.out_valid      (rsp_ch.valid),
		.out_ready      (rsp_ch.ready),
		.cursor_row_out (rsp_ch.cursor_row_out),
		.cursor_col_out (rsp_ch.cursor_col_out),
		.cell_value     (rsp_ch.cell_value),
		.scrolled       (rsp_ch.scrolled)
	);

endmodule

// ----- design/tcb_checker.sv -----
// port-level checks on the text console buffer, bound to the top level
module tcb_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [tcb_pkg::ROW_W-1:0]    rsp_row,
	input logic [tcb_pkg::COL_W-1:0]    rsp_col,
	input logic [tcb_pkg::CHAR_W-1:0]   rsp_cell,
	input logic                         rsp_scrolled
);

	// one item at a time: no request beat right after an accepted one
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on back-to-back cycles");

	// a scroll always leaves the cursor at column zero
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_scrolled |-> rsp_col == '0)
		else $error("scrolled response with nonzero cursor column");

	// only puts scroll and puts report an empty cell
	a_scroll_cell: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_scrolled |-> rsp_cell == '0)
		else $error("scrolled response carries a cell value");

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row) && $stable(rsp_col)
			&& $stable(rsp_cell) && $stable(rsp_scrolled))
		else $error("stalled response changed");

endmodule

bind text_console_buffer_unit tcb_checker u_tcb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (cmd_ch.valid),
	.req_ready    (cmd_ch.ready),
	.rsp_valid    (rsp_ch.valid),
	.rsp_ready    (rsp_ch.ready),
	.rsp_row      (rsp_ch.cursor_row_out),
	.rsp_col      (rsp_ch.cursor_col_out),
	.rsp_cell     (rsp_ch.cell_value),
	.rsp_scrolled (rsp_ch.scrolled)
);

// ----- tb/text_console_buffer_unit_tb.sv -----
// self-checking testbench for the text console buffer: directed and random beats with a tracker
`timescale 1ns / 1ps

module text_console_buffer_unit_tb;

	// cycles before the run is declared hung; the slowest legal run is far below this
	localparam int unsigned CYCLE_LIMIT = 5_000_000;
	// cycles the block may need to settle after its last report
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned SHOWN_ERRORS = 10;

	// one request beat as the block sees it
	typedef struct packed {
		tcb_pkg::op_t                op;
		logic [tcb_pkg::CHAR_W-1:0]  ch;
		logic [tcb_pkg::ROW_W-1:0]   row;
		logic [tcb_pkg::COL_W-1:0]   col;
	} console_req_t;

	// one response beat: cursor after the request, the cell read and the scroll flag
	typedef struct packed {
		logic [tcb_pkg::ROW_W-1:0]   row;
		logic [tcb_pkg::COL_W-1:0]   col;
		logic [tcb_pkg::CHAR_W-1:0]  cell_byte;
		logic                        scrolled;
	} console_rsp_t;

	// tracks the console contents and cursor, and checks each report in order
	class console_tracker;
		logic [tcb_pkg::CHAR_W-1:0]     cells [tcb_pkg::MEM_DEPTH];
		int unsigned                    cur_row;
		int unsigned                    cur_col;
		logic [tcb_pkg::CFG_COLS_W-1:0] cols_reg;
		logic [tcb_pkg::CFG_ROWS_W-1:0] rows_reg;
		console_rsp_t                   due_reports [$];
		int unsigned                    errors;

		function new();
			foreach (cells[i])
				cells[i] = '0;
			cur_row  = 0;
			cur_col  = 0;
			cols_reg = tcb_pkg::COLS_RESET;
			rows_reg = tcb_pkg::ROWS_RESET;
			errors   = 0;
		endfunction

		function void set_reg(tcb_pkg::cfg_idx_t idx, logic [tcb_pkg::CFG_DATA_W-1:0] val);
			if (idx == tcb_pkg::CFG_COLUMNS)
				cols_reg = val[tcb_pkg::CFG_COLS_W-1:0];
			else
				rows_reg = val[tcb_pkg::CFG_ROWS_W-1:0];
		endfunction

		// zero counts as one, oversize counts saturate
		function int unsigned eff_cols();
			if (cols_reg == 0)
				return 1;
			return (cols_reg > tcb_pkg::MAX_COLUMNS) ? tcb_pkg::MAX_COLUMNS : cols_reg;
		endfunction

		function int unsigned eff_rows();
			if (rows_reg == 0)
				return 1;
			return (rows_reg > tcb_pkg::MAX_ROWS) ? tcb_pkg::MAX_ROWS : rows_reg;
		endfunction

		// carriage to the next row, scrolling the whole active area when it falls off the bottom
		function bit next_row(int unsigned c, int unsigned r);
			int unsigned keep;
			cur_col = 0;
			cur_row++;
			if (cur_row < r)
				return 1'b0;
			keep = (r - 1) * c;
			for (int unsigned i = 0; i < keep; i++)
				cells[i] = cells[i + c];
			for (int unsigned i = 0; i < c; i++)
				cells[keep + i] = '0;
			cur_row--;
			return 1'b1;
		endfunction

		function void note_request(console_req_t rq);
			int unsigned  c;
			int unsigned  r;
			console_rsp_t rsp;
			c   = eff_cols();
			r   = eff_rows();
			rsp = '0;
			if (rq.op == tcb_pkg::OP_READ) begin
				if (rq.row < r && rq.col < c)
					rsp.cell_byte = cells[rq.row * c + rq.col];
			end else begin
				// a cursor left outside by a smaller setting is pulled back in first
				if (cur_row >= r)
					cur_row = r - 1;
				if (cur_col >= c)
					cur_col = c - 1;
				if (rq.ch == tcb_pkg::CH_NEWLINE) begin
					rsp.scrolled = next_row(c, r);
				end else if (rq.ch == tcb_pkg::CH_BACKSPACE) begin
					if (cur_col > 0)
						cur_col--;
					cells[cur_row * c + cur_col] = tcb_pkg::CH_SPACE;
				end else begin
					cells[cur_row * c + cur_col] = rq.ch;
					cur_col++;
					if (cur_col >= c)
						rsp.scrolled = next_row(c, r);
				end
			end
			rsp.row = tcb_pkg::ROW_W'(cur_row);
			rsp.col = tcb_pkg::COL_W'(cur_col);
			due_reports.push_back(rsp);
		endfunction

		function void check_report(console_rsp_t got);
			console_rsp_t want;
			bit           bad;
			string        what;
			if (due_reports.size() == 0) begin
				want = '0;
				bad  = 1'b1;
				what = "report with nothing outstanding";
			end else begin
				want = due_reports.pop_front();
				bad  = (got.row != want.row) || (got.col != want.col) ||
					(got.cell_byte != want.cell_byte) || (got.scrolled != want.scrolled);
				what = "report mismatch";
			end
			if (bad) begin
				errors++;
				if (errors <= SHOWN_ERRORS)
					$display({"%s: expected row %0d col %0d cell %0d scrolled %0d, ",
						"got row %0d col %0d cell %0d scrolled %0d"},
						what, want.row, want.col, want.cell_byte, want.scrolled,
						got.row, got.col, got.cell_byte, got.scrolled);
			end
		endfunction
	endclass

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_write;
	logic [tcb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [tcb_pkg::CFG_DATA_W-1:0] cfg_wdata;

	tcb_req_if cmd_ch ();
	tcb_rsp_if rsp_ch ();

	console_tracker sb;

	// chance in percent of a sender gap or a receiver stall in any one cycle
	int unsigned send_pct;
	int unsigned stall_pct;
	int unsigned cycle_count;

	text_console_buffer_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_ch    (cmd_ch),
		.rsp_ch    (rsp_ch),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// hang guard; the clearing pass after reset is well inside this budget
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("text_console_buffer_unit_tb: errors");
			$finish;
		end
	end

	// receiver: ready changes on the falling edge, held high when stalls are off
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// every accepted response beat goes to the tracker
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_report('{row: rsp_ch.cursor_row_out, col: rsp_ch.cursor_col_out,
				cell_byte: rsp_ch.cell_value, scrolled: rsp_ch.scrolled});
	end

	// idle patterns: none, sender gaps, receiver stalls, both at a lighter rate
	task automatic set_idling(int unsigned mode);
		case (mode % 4)
			0: begin
				send_pct  = 0;
				stall_pct = 0;
			end
			1: begin
				send_pct  = 67;
				stall_pct = 0;
			end
			2: begin
				send_pct  = 0;
				stall_pct = 67;
			end
			default: begin
				send_pct  = 33;
				stall_pct = 33;
			end
		endcase
	endtask

	// called on a falling edge; returns on the falling edge after the beat is taken
	task automatic send_beat(console_req_t rq);
		while ($urandom_range(99) < send_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.opcode    <= rq.op;
		cmd_ch.char_code <= rq.ch;
		cmd_ch.read_row  <= rq.row;
		cmd_ch.read_col  <= rq.col;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		sb.note_request(rq);
		@(negedge clk);
	endtask

	task automatic put_char(logic [tcb_pkg::CHAR_W-1:0] ch);
		send_beat('{op: tcb_pkg::OP_PUT, ch: ch, row: '0, col: '0});
	endtask

	task automatic read_cell(logic [tcb_pkg::ROW_W-1:0] row, logic [tcb_pkg::COL_W-1:0] col);
		send_beat('{op: tcb_pkg::OP_READ, ch: '0, row: row, col: col});
	endtask

	// drop valid and wait until every report is in, then let the block go quiet
	task automatic settle();
		cmd_ch.valid <= 1'b0;
		while (sb.due_reports.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// both registers back to back with the strobe held, so it is raised only once
	task automatic write_size(logic [tcb_pkg::CFG_DATA_W-1:0] cols,
		logic [tcb_pkg::CFG_DATA_W-1:0] rows);
		cfg_write <= 1'b1;
		cfg_index <= tcb_pkg::CFG_COLUMNS;
		cfg_wdata <= cols;
		@(negedge clk);
		sb.set_reg(tcb_pkg::CFG_COLUMNS, cols);
		cfg_index <= tcb_pkg::CFG_ROWS;
		cfg_wdata <= rows;
		@(negedge clk);
		sb.set_reg(tcb_pkg::CFG_ROWS, rows);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	// random beat: mostly text with line control mixed in, a quarter of reads
	function automatic console_req_t random_req();
		console_req_t rq;
		int unsigned  pick;
		rq   = '0;
		pick = $urandom_range(99);
		if (pick < 25) begin
			rq.op = tcb_pkg::OP_READ;
			if ($urandom_range(1) == 0) begin
				// anywhere in the field, often outside the active area
				rq.row = tcb_pkg::ROW_W'($urandom_range(63));
				rq.col = tcb_pkg::COL_W'($urandom_range(127));
			end else begin
				rq.row = tcb_pkg::ROW_W'($urandom_range(sb.eff_rows() - 1));
				rq.col = tcb_pkg::COL_W'($urandom_range(sb.eff_cols() - 1));
			end
		end else begin
			rq.op = tcb_pkg::OP_PUT;
			if (pick < 37)
				rq.ch = tcb_pkg::CH_NEWLINE;
			else if (pick < 46)
				rq.ch = tcb_pkg::CH_BACKSPACE;
			else
				rq.ch = tcb_pkg::CHAR_W'($urandom_range(255));
			// junk in the read fields must not matter on a put
			rq.row = tcb_pkg::ROW_W'($urandom_range(63));
			rq.col = tcb_pkg::COL_W'($urandom_range(127));
		end
		return rq;
	endfunction

	task automatic run_phase(logic [tcb_pkg::CFG_DATA_W-1:0] cols,
		logic [tcb_pkg::CFG_DATA_W-1:0] rows, int unsigned beats, int unsigned mode);
		settle();
		write_size(cols, rows);
		set_idling(mode);
		repeat (beats)
			send_beat(random_req());
	endtask

	initial begin
		sb               = new();
		cycle_count      = 0;
		send_pct         = 0;
		stall_pct        = 0;
		arst_n           = 1'b0;
		cfg_write        = 1'b0;
		cfg_index        = tcb_pkg::CFG_COLUMNS;
		cfg_wdata        = '0;
		cmd_ch.valid     = 1'b0;
		cmd_ch.opcode    = tcb_pkg::OP_PUT;
		cmd_ch.char_code = '0;
		cmd_ch.read_row  = '0;
		cmd_ch.read_col  = '0;
		rsp_ch.ready     = 1'b1;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: reset size 80 x 25, cursor at the origin
		read_cell(6'd0, 7'd0);                // cleared store reads zero
		put_char(8'd72);
		put_char(8'd0);                       // a zero byte is stored like any other
		put_char(8'd255);
		put_char(tcb_pkg::CH_BACKSPACE);      // steps back and blanks the cell
		read_cell(6'd0, 7'd2);
		read_cell(6'd0, 7'd1);
		read_cell(6'd63, 7'd127);             // far outside the active area
		read_cell(6'd24, 7'd79);              // last cell of the active area
		put_char(tcb_pkg::CH_NEWLINE);
		put_char(tcb_pkg::CH_BACKSPACE);      // at column zero the cursor stays put
		read_cell(6'd1, 7'd0);
		for (int i = 0; i < 5; i++)
			put_char(8'd97 + tcb_pkg::CHAR_W'(i));

		// shrink to 4 x 2 with the cursor at column 5, outside the new area
		settle();
		write_size(8'd4, 8'd2);
		read_cell(6'd1, 7'd3);                // cursor is reported as stored
		put_char("x");                        // clamped, then wraps off the bottom row and scrolls
		read_cell(6'd0, 7'd3);
		read_cell(6'd1, 7'd0);                // bottom row cleared by the scroll
		put_char(tcb_pkg::CH_NEWLINE);        // newline on the bottom row scrolls again
		read_cell(6'd0, 7'd0);

		// random phases over a spread of sizes, idling pattern rotating with the phase
		run_phase(8'd8,   8'd4,   150, 0);
		run_phase(8'd0,   8'd2,   100, 1);   // zero columns act as one
		run_phase(8'd255, 8'd0,   80,  2);   // columns saturate, zero rows act as one
		run_phase(8'd16,  8'd8,   200, 3);
		run_phase(8'd3,   8'd127, 120, 0);   // rows saturate
		run_phase(8'd128, 8'd64,  40,  1);   // full size: every scroll copies the whole store
		run_phase(8'd5,   8'd3,   150, 2);
		run_phase(8'd80,  8'd25,  80,  3);
		run_phase(8'd32,  8'd2,   150, 0);
		run_phase(8'd7,   8'h85,  150, 1);   // top data bit is dropped for the row count
		run_phase(8'd2,   8'd64,  120, 2);
		run_phase(8'd1,   8'd1,   60,  3);

		settle();
		if (sb.due_reports.size() != 0) begin
			sb.errors += sb.due_reports.size();
			$display("%0d reports never arrived", sb.due_reports.size());
		end
		if (sb.errors == 0) begin
			$display("text_console_buffer_unit_tb: clean");
		end else begin
			$display("text_console_buffer_unit_tb: errors");
		end
		$finish;
	end

endmodule
